@@ design/lhist_pkg.sv @@
// Package: shared types and constants for the letter histogram block.
`timescale 1ns / 1ps
`default_nettype none
package lhist_pkg;

  localparam int COUNT_BITS  = 24;
  localparam int NUM_LETTERS = 26;
  localparam int LETTER_W    = 5;
  localparam int TOP_COUNT_W = 24;
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
  localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(NUM_LETTERS - 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } lhist_in_t;

  typedef struct packed {
    logic [LETTER_W-1:0]    top_letter;
    logic [TOP_COUNT_W-1:0] top_count;
    logic                   any_letter;
  } lhist_out_t;

  // Classified beat passed from front to back.
  typedef struct packed {
    logic                is_letter;
    logic [LETTER_W-1:0] letter;
    logic                eos;
  } lhist_entry_t;

endpackage
`default_nettype wire

@@ design/letter_histogram_argmax.sv @@
// Top level: letter histogram with most-frequent-letter report.
//
// Bytes are taken one per cycle while busy is low; letters are folded to
// lower case and counted in 26 saturating counters. The beat carrying
// end_of_stream is counted, then a scan walks the counters a to z, one per
// cycle, so the result appears on done/result for a single cycle when the
// scan reaches z; the scan starts later when the queue still holds earlier beats.
// The receiver cannot stall: result must be captured
// in the cycle done is high. During the scan a 4-entry queue keeps taking
// bytes; once it fills, busy stays high until the scan finishes. Counters
// clear as each result is registered.
`timescale 1ns / 1ps
`default_nettype none
module letter_histogram_argmax import lhist_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire lhist_in_t item,
  output logic           busy,
  output lhist_out_t     result,
  output logic           done
);

  logic         q_full;
  logic         q_empty;
  logic         push;
  logic         pop;
  lhist_entry_t push_entry;
  lhist_entry_t head;

  lhist_front u_front (
    .start      (start),
    .item       (item),
    .q_full     (q_full),
    .busy       (busy),
    .push       (push),
    .push_entry (push_entry)
  );

  lhist_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  lhist_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (q_empty),
    .pop    (pop),
    .result (result),
    .done   (done)
  );

endmodule
`default_nettype wire

@@ design/lhist_front.sv @@
// Front end: accepts beats, folds case and classifies letters for the queue.
`timescale 1ns / 1ps
`default_nettype none
module lhist_front import lhist_pkg::*; (
  input  wire logic         start,
  input  wire lhist_in_t    item,
  input  wire logic         q_full,
  output logic              busy,
  output logic              push,
  output lhist_entry_t      push_entry
);

  logic       is_upper;
  logic       is_lower;
  logic [7:0] offset;

  always_comb begin
    is_upper = (item.data_byte >= ASCII_UPPER_A) && (item.data_byte <= ASCII_UPPER_Z);
    is_lower = (item.data_byte >= ASCII_LOWER_A) && (item.data_byte <= ASCII_LOWER_Z);
    offset   = is_upper ? (item.data_byte - ASCII_UPPER_A) : (item.data_byte - ASCII_LOWER_A);
    push_entry.is_letter = is_upper || is_lower;
    push_entry.letter    = offset[LETTER_W-1:0];
    push_entry.eos       = item.end_of_stream;
    busy = q_full;
    // non-letters without the end mark change nothing and are dropped here
    push = start && !q_full && (push_entry.is_letter || push_entry.eos);
  end

endmodule
`default_nettype wire

@@ design/lhist_queue.sv @@
// Short FIFO of classified beats between front and back.
`timescale 1ns / 1ps
`default_nettype none
module lhist_queue import lhist_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire lhist_entry_t push_entry,
  input  wire logic         pop,
  output lhist_entry_t      head,
  output logic              empty,
  output logic              full
);

  lhist_entry_t       mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign empty   = (count == '0);
  assign full    = (count == Q_CNT_W'(Q_DEPTH));
  assign head    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/lhist_back.sv @@
// Back end: letter counters, end-of-stream scan for the maximum, result beat.
`timescale 1ns / 1ps
`default_nettype none
module lhist_back import lhist_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire lhist_entry_t head,
  input  wire logic         empty,
  output logic              pop,
  output lhist_out_t        result,
  output logic              done
);

  typedef enum logic [0:0] {
    ST_COUNT,
    ST_SCAN
  } state_t;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  state_t                  state;
  logic [COUNT_BITS-1:0]   counts [NUM_LETTERS];
  logic [LETTER_W-1:0]     scan_idx;
  logic [COUNT_BITS-1:0]   best;
  logic [LETTER_W-1:0]     best_idx;
  logic [COUNT_BITS-1:0]   cur;
  logic                    take;
  logic [COUNT_BITS-1:0]   best_next;
  logic [LETTER_W-1:0]     best_idx_next;
  logic [COUNT_BITS+TOP_COUNT_W-1:0] best_wide;
  logic                    scan_last;

  assign pop           = (state == ST_COUNT) && !empty;
  assign cur           = counts[scan_idx];
  assign take          = cur > best;
  assign best_next     = take ? cur : best;
  assign best_idx_next = take ? scan_idx : best_idx;
  assign best_wide     = {{TOP_COUNT_W{1'b0}}, best_next};
  assign scan_last     = (state == ST_SCAN) && (scan_idx == LAST_LETTER);

  for (genvar i = 0; i < NUM_LETTERS; i++) begin : g_lane
    always_ff @(posedge clk) begin
      if (rst || scan_last) begin
        counts[i] <= '0;
      end else if (pop && head.is_letter && (head.letter == LETTER_W'(i))
                   && (counts[i] != COUNT_MAX)) begin
        counts[i] <= counts[i] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_COUNT;
      scan_idx <= '0;
      best     <= '0;
      best_idx <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_COUNT: begin
          if (pop && head.eos) begin
            state    <= ST_SCAN;
            scan_idx <= '0;
            best     <= '0;
            best_idx <= '0;
          end
        end
        ST_SCAN: begin
          best     <= best_next;
          best_idx <= best_idx_next;
          scan_idx <= scan_idx + 1'b1;
          if (scan_last) begin
            state             <= ST_COUNT;
            done              <= 1'b1;
            result.top_letter <= best_idx_next;
            result.top_count  <= best_wide[TOP_COUNT_W-1:0];
            result.any_letter <= (best_next != '0);
          end
        end
        default: state <= ST_COUNT;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ tb/tb_letter_histogram_argmax.sv @@
// Testbench: letter_histogram_argmax byte streams checked against a letter-count predictor.
`timescale 1ns / 1ps
module tb_letter_histogram_argmax;
  import lhist_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_ITEMS = 550;
  localparam int NOT_A_LETTER = -1;

  logic       clk   = 1'b0;
  logic       rst   = 1'b1;
  logic       start = 1'b0;
  lhist_in_t  item  = '0;
  logic       busy;
  lhist_out_t result;
  logic       done;

  logic [COUNT_BITS-1:0] letter_tally [NUM_LETTERS];
  lhist_out_t            pending_tops [$];
  lhist_out_t            want;
  int                    fail_count = 0;
  int                    burst_left = 0;

  letter_histogram_argmax DUT (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .busy  (busy),
    .result(result),
    .done  (done)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("** letter_histogram_argmax: FAILED **");
    $finish;
  end

  function automatic int letter_slot(input logic [7:0] b);
    if (b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) return int'(b - ASCII_UPPER_A);
    if (b >= ASCII_LOWER_A && b <= ASCII_LOWER_Z) return int'(b - ASCII_LOWER_A);
    return NOT_A_LETTER;
  endfunction

  task automatic note_failure(input string what, input lhist_out_t exp_v,
                              input lhist_out_t got_v);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t: %s: expected letter=%0d count=%0d any=%0b, got letter=%0d count=%0d any=%0b",
               $realtime, what, exp_v.top_letter, exp_v.top_count, exp_v.any_letter,
               got_v.top_letter, got_v.top_count, got_v.any_letter);
  endtask

  // Predictor: tally the beat, on end of stream scan a..z and queue the top letter.
  task automatic tally_beat(input lhist_in_t beat);
    int                    slot;
    logic [COUNT_BITS-1:0] best;
    lhist_out_t            top;
    slot = letter_slot(beat.data_byte);
    if (slot != NOT_A_LETTER && letter_tally[slot] != {COUNT_BITS{1'b1}})
      letter_tally[slot]++;
    if (beat.end_of_stream) begin
      best = '0;
      top  = '0;
      for (int i = 0; i < NUM_LETTERS; i++) begin
        if (letter_tally[i] > best) begin
          best           = letter_tally[i];
          top.top_letter = LETTER_W'(i);
        end
      end
      top.top_count  = TOP_COUNT_W'(best);
      top.any_letter = (best != '0);
      pending_tops.push_back(top);
      foreach (letter_tally[i]) letter_tally[i] = '0;
    end
  endtask

  task automatic send_beat(input logic [7:0] b, input logic eos);
    int        gap;
    lhist_in_t beat;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    beat.data_byte     = b;
    beat.end_of_stream = eos;
    start <= 1'b1;
    item  <= beat;
    do @(posedge clk); while (busy);
    tally_beat(beat);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_beat(s[i], i == s.len() - 1);
  endtask

  task automatic test_empty_streams();
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b1);
  endtask

  task automatic test_case_folding();
    send_text("aAbB");
  endtask

  // Neighbors of the letter ranges and high bytes whose low bits look like letters.
  task automatic test_letter_edges();
    send_beat(8'h40, 1'b0);
    send_beat(8'h5B, 1'b0);
    send_beat(8'h60, 1'b0);
    send_beat(8'h7B, 1'b0);
    send_beat(8'hC1, 1'b0);
    send_beat(8'hE1, 1'b0);
    send_beat(8'h80, 1'b0);
    send_text("zZ");
  endtask

  task automatic test_ties();
    send_text("yxxy");
    send_text("cbb");
  endtask

  function automatic logic [7:0] pick_byte(input int mode, input int base, input int span);
    int slot;
    if (mode >= 3 && $urandom_range(0, 9) != 0) begin
      slot = base + $urandom_range(0, span);
      if (slot > NUM_LETTERS - 1) slot = NUM_LETTERS - 1;
      return (($urandom_range(0, 1) == 0) ? ASCII_LOWER_A : ASCII_UPPER_A) + 8'(slot);
    end
    if (mode == 0) return 8'($urandom_range(0, 255)) & 8'h3F;
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly letter-heavy streams over a narrow alphabet so ties are common.
  task automatic test_random_streams();
    int         counted;
    int         mode;
    int         base;
    int         span;
    int         len;
    logic [7:0] b;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 9);
      base = $urandom_range(0, NUM_LETTERS - 1);
      span = $urandom_range(0, 3);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
      for (int i = 0; i <= len; i++) begin
        b = pick_byte(mode, base, span);
        send_beat(b, i == len);
        counted++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_tops.size() == 0) begin
        note_failure("result with none expected", '0, result);
      end else begin
        want = pending_tops.pop_front();
        if (result.top_letter !== want.top_letter || result.top_count !== want.top_count ||
            result.any_letter !== want.any_letter)
          note_failure("result mismatch", want, result);
      end
    end
  end

  initial begin
    foreach (letter_tally[i]) letter_tally[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_empty_streams();
    test_case_folding();
    test_letter_edges();
    test_ties();
    test_random_streams();

    start <= 1'b0;
    while (pending_tops.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (pending_tops.size() != 0) begin
      note_failure("result never arrived", pending_tops.pop_front(), '0);
    end

    if (fail_count == 0) begin
      $display("** letter_histogram_argmax: PASSED **");
    end else begin
      $display("** letter_histogram_argmax: FAILED **");
    end
    $finish;
  end

endmodule
